### hdl/sbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared constants, opcode numbers and types of the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned LOCAL_COUNT = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W    = $clog2(STACK_DEPTH);
  localparam int unsigned LOC_W   = $clog2(LOCAL_COUNT);
  localparam int unsigned CFG_IDX_W = $clog2(LOCAL_COUNT);

  localparam int unsigned SLOT_W  = 64;
  localparam int unsigned IP_W    = 16;
  localparam int unsigned OP_W    = 8;
  localparam int unsigned ST_W    = 3;

  localparam logic [OP_W-1:0] OP_ILOAD_0  = 8'd26;
  localparam logic [OP_W-1:0] OP_ILOAD_3  = 8'd29;
  localparam logic [OP_W-1:0] OP_LLOAD_0  = 8'd30;
  localparam logic [OP_W-1:0] OP_LLOAD_3  = 8'd33;
  localparam logic [OP_W-1:0] OP_ALOAD_0  = 8'd42;
  localparam logic [OP_W-1:0] OP_ASTORE_0 = 8'd75;
  localparam logic [OP_W-1:0] OP_DUP      = 8'd89;
  localparam logic [OP_W-1:0] OP_IADD     = 8'd96;
  localparam logic [OP_W-1:0] OP_LADD     = 8'd97;
  localparam logic [OP_W-1:0] OP_GOTO     = 8'd167;
  localparam logic [OP_W-1:0] OP_IRETURN  = 8'd172;
  localparam logic [OP_W-1:0] OP_LRETURN  = 8'd173;
  localparam logic [OP_W-1:0] OP_RETURN   = 8'd177;

  localparam logic [ST_W-1:0] ST_RUN     = 3'd0;
  localparam logic [ST_W-1:0] ST_RETVAL  = 3'd1;
  localparam logic [ST_W-1:0] ST_RETVOID = 3'd2;
  localparam logic [ST_W-1:0] ST_BADOP   = 3'd3;
  localparam logic [ST_W-1:0] ST_OVER    = 3'd4;
  localparam logic [ST_W-1:0] ST_UNDER   = 3'd5;

  typedef enum logic [3:0] {
    CLS_LOAD,
    CLS_STORE,
    CLS_DUP,
    CLS_IADD,
    CLS_LADD,
    CLS_GOTO,
    CLS_RETVAL,
    CLS_RETVOID,
    CLS_BAD
  } op_class_e;

  typedef struct packed {
    op_class_e         cls;
    logic [LOC_W-1:0]  src;
    logic [IP_W-1:0]   offs;
  } uop_t;

endpackage

### hdl/stack_bytecode_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_core
// Executes one stack-machine bytecode per input word and reports the next
// instruction address, a status code and any return value.
// ----------------------------------------------------------------------------
// The block takes one instruction word per clock cycle while the queue
// has room and returns one result word per instruction, in order. Each
// word waits in the decode queue; the execute stage then updates the two
// cached top-of-stack registers and the stack RAM together and registers
// its result, one word per cycle while results are accepted. Argument
// registers must be written through the cfg port only while no word is in
// flight; the block does not enforce this. The first instruction after reset
// or a return starts a new frame and copies them into the local slots.
module stack_bytecode_executor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sbe_pkg::SLOT_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sbe_pkg::OP_W-1:0]      opcode_i,
  input  logic signed [sbe_pkg::IP_W-1:0] branch_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sbe_pkg::IP_W-1:0]      next_ip_o,
  output logic [sbe_pkg::ST_W-1:0]      status_o,
  output logic signed [sbe_pkg::SLOT_W-1:0] return_value_o
);
  import sbe_pkg::*;

  uop_t dec_uop, q_uop;
  logic q_valid, q_ready;

  sbe_front u_front (
    .opcode_i        (opcode_i),
    .branch_offset_i (branch_offset_i),
    .uop_o           (dec_uop)
  );

  sbe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (dec_uop),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_uop)
  );

  sbe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .uop_valid_i    (q_valid),
    .uop_ready_o    (q_ready),
    .uop_i          (q_uop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_ip_o      (next_ip_o),
    .status_o       (status_o),
    .return_value_o (return_value_o)
  );

endmodule

### hdl/sbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/sbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_front
// Opcode decoder: sorts each incoming word into an operation class.
// ----------------------------------------------------------------------------
module sbe_front (
  input  logic [sbe_pkg::OP_W-1:0] opcode_i,
  input  logic [sbe_pkg::IP_W-1:0] branch_offset_i,
  output sbe_pkg::uop_t            uop_o
);
  import sbe_pkg::*;

  logic [OP_W-1:0] rel;

  always_comb begin
    rel        = opcode_i - OP_ILOAD_0;
    uop_o.src  = rel[LOC_W-1:0];
    uop_o.offs = branch_offset_i;
    case (opcode_i) inside
      [OP_ILOAD_0:OP_ILOAD_3],
      [OP_LLOAD_0:OP_LLOAD_3]: uop_o.cls = CLS_LOAD;
      OP_ALOAD_0: begin
        uop_o.cls = CLS_LOAD;
        uop_o.src = '0;
      end
      OP_ASTORE_0:             uop_o.cls = CLS_STORE;
      OP_DUP:                  uop_o.cls = CLS_DUP;
      OP_IADD:                 uop_o.cls = CLS_IADD;
      OP_LADD:                 uop_o.cls = CLS_LADD;
      OP_GOTO:                 uop_o.cls = CLS_GOTO;
      OP_IRETURN, OP_LRETURN:  uop_o.cls = CLS_RETVAL;
      OP_RETURN:               uop_o.cls = CLS_RETVOID;
      default:                 uop_o.cls = CLS_BAD;
    endcase
  end

endmodule

### hdl/sbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_queue
// Short FIFO of decoded words between the decoder and the execute stage.
// ----------------------------------------------------------------------------
module sbe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  sbe_pkg::uop_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output sbe_pkg::uop_t rd_data_o
);
  import sbe_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  uop_t             buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = buf_q[rptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/sbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_back
// Execute stage: frame state, operand stack and the result register.
// Top two stack slots live in registers, deeper slots in a RAM.
// ----------------------------------------------------------------------------
module sbe_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbe_pkg::SLOT_W-1:0]       cfg_data_i,
  input  logic                             uop_valid_i,
  output logic                             uop_ready_o,
  input  sbe_pkg::uop_t                    uop_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sbe_pkg::IP_W-1:0]         next_ip_o,
  output logic [sbe_pkg::ST_W-1:0]         status_o,
  output logic [sbe_pkg::SLOT_W-1:0]       return_value_o
);
  import sbe_pkg::*;

  logic [SLOT_W-1:0] arg_q [LOCAL_COUNT];
  logic [SLOT_W-1:0] loc_q [LOCAL_COUNT];
  logic [SLOT_W-1:0] loc_d [LOCAL_COUNT];
  logic [SLOT_W-1:0] loc_eff [LOCAL_COUNT];
  logic [SLOT_W-1:0] top_q, top_d, nos_q, nos_d, third, byp_data_q, push_val;
  logic [SP_W-1:0]   sp_q, sp_d, sp_eff, sp_nxt;
  logic [IP_W-1:0]   ip_q, ip_d, start, nip;
  logic              frame_q, frame_d, byp_q;
  logic              exec, ram_we, do_push;
  logic [SA_W-1:0]   ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  logic [31:0]       lo_sum;
  logic              out_valid_q;
  logic [IP_W-1:0]   nip_q;
  logic [ST_W-1:0]   st_q, st;
  logic [SLOT_W-1:0] rv_q, rv;

  assign uop_ready_o = ~out_valid_q | out_ready_i;
  assign exec        = uop_valid_i & uop_ready_o;

  always_comb begin
    sp_eff = frame_q ? sp_q : '0;
    start  = frame_q ? ip_q : '0;
    for (int i = 0; i < LOCAL_COUNT; i++) begin
      loc_eff[i] = frame_q ? loc_q[i] : arg_q[i];
    end
    third = byp_q ? byp_data_q : ram_rdata;
  end

  always_comb begin
    sp_d     = sp_eff;
    ip_d     = start;
    frame_d  = 1'b1;
    top_d    = top_q;
    nos_d    = nos_q;
    loc_d    = loc_eff;
    nip      = start + 1'b1;
    st       = ST_RUN;
    rv       = '0;
    do_push  = 1'b0;
    push_val = top_q;
    lo_sum   = nos_q[31:0] + top_q[31:0];
    case (uop_i.cls)
      CLS_LOAD: begin
        if (sp_eff >= SP_W'(STACK_DEPTH)) begin
          st = ST_OVER;
        end else begin
          do_push  = 1'b1;
          push_val = loc_eff[uop_i.src];
        end
      end
      CLS_DUP: begin
        if (sp_eff == '0) begin
          st = ST_UNDER;
        end else if (sp_eff >= SP_W'(STACK_DEPTH)) begin
          st = ST_OVER;
        end else begin
          do_push = 1'b1;
        end
      end
      CLS_STORE: begin
        if (sp_eff == '0) begin
          st = ST_UNDER;
        end else begin
          loc_d[0] = top_q;
          top_d    = nos_q;
          nos_d    = third;
          sp_d     = sp_eff - 1'b1;
          ip_d     = nip;
        end
      end
      CLS_IADD, CLS_LADD: begin
        if (sp_eff < SP_W'(2)) begin
          st = ST_UNDER;
        end else begin
          top_d = (uop_i.cls == CLS_IADD) ? {nos_q[63:32], lo_sum} : nos_q + top_q;
          nos_d = third;
          sp_d  = sp_eff - 1'b1;
          ip_d  = nip;
        end
      end
      CLS_GOTO: begin
        nip  = start + uop_i.offs;
        ip_d = nip;
      end
      CLS_RETVAL: begin
        if (sp_eff == '0) begin
          st = ST_UNDER;
        end else begin
          rv      = top_q;
          st      = ST_RETVAL;
          frame_d = 1'b0;
          sp_d    = '0;
          ip_d    = '0;
          nip     = '0;
        end
      end
      CLS_RETVOID: begin
        st      = ST_RETVOID;
        frame_d = 1'b0;
        sp_d    = '0;
        ip_d    = '0;
        nip     = '0;
      end
      default: begin
        st = ST_BADOP;
      end
    endcase
    if (do_push) begin
      top_d = push_val;
      nos_d = top_q;
      sp_d  = sp_eff + 1'b1;
      ip_d  = nip;
    end
    // errors report the faulting address and leave the stack alone
    if (st == ST_OVER || st == ST_UNDER || st == ST_BADOP) begin
      nip = start;
    end
  end

  // slot below the cached pair spills to RAM on push; RAM is read at sp-3
  assign ram_we    = exec & do_push & (sp_eff >= SP_W'(2));
  assign ram_waddr = SA_W'(sp_eff - SP_W'(2));
  assign sp_nxt    = exec ? sp_d : sp_q;
  assign ram_raddr = SA_W'(sp_nxt - SP_W'(3));

  sbe_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOCAL_COUNT; i++) begin
        arg_q[i] <= '0;
      end
      sp_q        <= '0;
      ip_q        <= '0;
      frame_q     <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arg_q[cfg_idx_i] <= cfg_data_i;
      end
      byp_q       <= ram_we;
      out_valid_q <= exec | (out_valid_q & ~out_ready_i);
      if (exec) begin
        sp_q    <= sp_d;
        ip_q    <= ip_d;
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_data_q <= nos_q;
    end
    if (exec) begin
      top_q <= top_d;
      nos_q <= nos_d;
      loc_q <= loc_d;
      nip_q <= nip;
      st_q  <= st;
      rv_q  <= rv;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_ip_o      = nip_q;
  assign status_o       = st_q;
  assign return_value_o = rv_q;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stack_bytecode_executor_core.
// ----------------------------------------------------------------------------
// Bytecode words are queued by the stimulus process and presented by a
// valid/ready driver. A behavioural executor predicts each result word when
// its instruction is taken. The monitor compares every result word, field by
// field, against the oldest prediction. Argument registers are rewritten
// between phases while nothing is in flight. The stimulus runs a directed
// sequence first, then random programs. Most programs are mixed,
// some are push-heavy and can run into overflow, and the rest are noise. Idle
// patterns change between groups of phases, and one phase includes a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 288;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [OP_W-1:0] OP_NOP           = 8'd0;
  localparam logic [OP_W-1:0] OP_INVOKESPECIAL = 8'd183;
  localparam logic [OP_W-1:0] OP_NEW           = 8'd187;
  localparam logic [OP_W-1:0] OP_IMPDEP2       = 8'd255;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [IP_W-1:0] offs;
  } bytecode_t;

  typedef struct packed {
    logic [IP_W-1:0]   nip;
    logic [ST_W-1:0]   st;
    logic [SLOT_W-1:0] rv;
  } outcome_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [SLOT_W-1:0]    cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic [OP_W-1:0]      opcode_i        = '0;
  logic [IP_W-1:0]      branch_offset_i = '0;
  logic                 out_ready_i     = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [IP_W-1:0]      next_ip_o;
  logic [ST_W-1:0]      status_o;
  logic [SLOT_W-1:0]    return_value_o;

  stack_bytecode_executor_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .branch_offset_i(branch_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_ip_o      (next_ip_o),
    .status_o       (status_o),
    .return_value_o (return_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // executor state as the block should hold it
  logic [SLOT_W-1:0] arg_regs     [LOCAL_COUNT] = '{default: '0};
  logic [SLOT_W-1:0] frame_locals [LOCAL_COUNT] = '{default: '0};
  logic [SLOT_W-1:0] opnd_stack   [STACK_DEPTH] = '{default: '0};
  int unsigned       stack_ptr = 0;
  logic [IP_W-1:0]   cur_ip    = '0;
  logic              in_frame  = 1'b0;

  function automatic outcome_t exec_bytecode(input bytecode_t bc);
    outcome_t          res;
    logic [IP_W-1:0]   start;
    logic [OP_W-1:0]   rel;
    logic [SLOT_W-1:0] lhs;
    logic [SLOT_W-1:0] rhs;
    if (!in_frame) begin
      frame_locals = arg_regs;
      stack_ptr    = 0;
      cur_ip       = '0;
      in_frame     = 1'b1;
    end
    start   = cur_ip;
    res.nip = start + 1'b1;
    res.st  = ST_RUN;
    res.rv  = '0;
    if ((bc.op >= OP_ILOAD_0 && bc.op <= OP_LLOAD_3) || bc.op == OP_ALOAD_0) begin
      rel = bc.op - OP_ILOAD_0;
      if (stack_ptr >= STACK_DEPTH) begin
        res.st = ST_OVER;
      end else begin
        opnd_stack[stack_ptr] = (bc.op == OP_ALOAD_0) ? frame_locals[0]
                                                       : frame_locals[rel[LOC_W-1:0]];
        stack_ptr++;
      end
    end else if (bc.op == OP_ASTORE_0) begin
      if (stack_ptr < 1) begin
        res.st = ST_UNDER;
      end else begin
        stack_ptr--;
        frame_locals[0] = opnd_stack[stack_ptr];
      end
    end else if (bc.op == OP_DUP) begin
      if (stack_ptr < 1) begin
        res.st = ST_UNDER;
      end else if (stack_ptr >= STACK_DEPTH) begin
        res.st = ST_OVER;
      end else begin
        opnd_stack[stack_ptr] = opnd_stack[stack_ptr-1];
        stack_ptr++;
      end
    end else if (bc.op == OP_IADD || bc.op == OP_LADD) begin
      if (stack_ptr < 2) begin
        res.st = ST_UNDER;
      end else begin
        stack_ptr--;
        rhs = opnd_stack[stack_ptr];
        lhs = opnd_stack[stack_ptr-1];
        if (bc.op == OP_IADD) begin
          lhs[31:0] = lhs[31:0] + rhs[31:0];
        end else begin
          lhs = lhs + rhs;
        end
        opnd_stack[stack_ptr-1] = lhs;
      end
    end else if (bc.op == OP_GOTO) begin
      res.nip = start + bc.offs;
    end else if (bc.op == OP_IRETURN || bc.op == OP_LRETURN) begin
      if (stack_ptr < 1) begin
        res.st = ST_UNDER;
      end else begin
        stack_ptr--;
        res.rv = opnd_stack[stack_ptr];
        res.st = ST_RETVAL;
      end
    end else if (bc.op == OP_RETURN) begin
      res.st = ST_RETVOID;
    end else begin
      res.st = ST_BADOP;
    end

    if (res.st == ST_RETVAL || res.st == ST_RETVOID) begin
      in_frame = 1'b0;
      cur_ip   = '0;
      res.nip  = '0;
    end else if (res.st != ST_RUN) begin
      res.nip = start;
    end else begin
      cur_ip = res.nip;
    end
    return res;
  endfunction

  bytecode_t   pending_words[$];
  outcome_t    expected_results[$];
  outcome_t    want;
  int unsigned err_cnt    = 0;
  logic        word_taken = 1'b0;

  always @(posedge clk_i) begin
    word_taken = rst_ni && in_valid_i && in_ready_o;
    if (word_taken) begin
      expected_results.push_back(exec_bytecode({opcode_i, branch_offset_i}));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: next_ip %0h status %0d", next_ip_o, status_o);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (next_ip_o !== want.nip) begin
          $error("next_ip: expected %0h, got %0h", want.nip, next_ip_o);
          err_cnt++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status_o);
          err_cnt++;
        end
        if (return_value_o !== want.rv) begin
          $error("return_value: expected %0h, got %0h", want.rv, return_value_o);
          err_cnt++;
        end
      end
    end
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bytecode_t   next_word;
  logic        drive_valid;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      drive_valid = in_valid_i && !word_taken;
      if (!drive_valid && pending_words.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        opcode_i        <= next_word.op;
        branch_offset_i <= next_word.offs;
        drive_valid = 1'b1;
      end
      in_valid_i <= drive_valid;
    end
  end

  int unsigned hold_left = 0;
  logic        hold_arm  = 1'b0;
  logic        hold_used = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  int unsigned queued = 0;

  task automatic add_word(input logic [OP_W-1:0] op, input logic [IP_W-1:0] offs);
    pending_words.push_back({op, offs});
    queued++;
  endtask

  function automatic logic [OP_W-1:0] pick_load();
    if ($urandom_range(8) == 8) begin
      return OP_ALOAD_0;
    end
    return OP_ILOAD_0 + OP_W'($urandom_range(7));
  endfunction

  function automatic logic [OP_W-1:0] pick_return();
    case ($urandom_range(2))
      0: return OP_IRETURN;
      1: return OP_LRETURN;
      default: return OP_RETURN;
    endcase
  endfunction

  // noise, push-heavy programs that can run into overflow, or mixed programs
  task automatic gen_program();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    logic [OP_W-1:0] op;
    kind = $urandom_range(99);
    if (kind < 20) begin
      len = $urandom_range(6, 1);
      repeat (len) add_word(OP_W'($urandom), IP_W'($urandom));
    end else begin
      len = (kind < 40) ? $urandom_range(28, 16) : $urandom_range(12, 1);
      repeat (len) begin
        pick = $urandom_range(99);
        if (kind < 40 && pick < 70) pick = pick % 45;
        if (pick < 35)      op = pick_load();
        else if (pick < 45) op = OP_DUP;
        else if (pick < 57) op = OP_IADD;
        else if (pick < 69) op = OP_LADD;
        else if (pick < 77) op = OP_ASTORE_0;
        else if (pick < 87) op = OP_GOTO;
        else if (pick < 90) op = pick_return();
        else                op = OP_W'($urandom);
        add_word(op, IP_W'($urandom));
      end
      if ($urandom_range(9) != 0) add_word(pick_return(), IP_W'($urandom));
    end
  endtask

  task automatic load_args(input logic [SLOT_W-1:0] a0, input logic [SLOT_W-1:0] a1,
                           input logic [SLOT_W-1:0] a2, input logic [SLOT_W-1:0] a3);
    logic [SLOT_W-1:0] vals [LOCAL_COUNT];
    vals = '{a0, a1, a2, a3};
    for (int i = 0; i < LOCAL_COUNT; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      arg_regs[i] = vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SLOT_W-1:0] rand_slot();
    logic [SLOT_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v[31:0]  = '1;
      1: v[63:32] = '1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_args(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    send_idle_pct = 32;
    recv_idle_pct = 50;

    add_word(OP_RETURN,        16'h8000);
    add_word(OP_IRETURN,       16'h7FFF);
    add_word(OP_ASTORE_0,      16'hFFFF);
    add_word(OP_DUP,           16'h0000);
    add_word(OP_ILOAD_0,       16'h5A5A);
    add_word(OP_IADD,          16'hA5A5);
    add_word(OP_LLOAD_3,       16'h0001);
    add_word(OP_IADD,          16'h1234);  // low half carries out and wraps
    add_word(OP_ILOAD_0 + 8'd1, 16'h0);
    add_word(OP_LADD,          16'h0);
    add_word(OP_DUP,           16'h0);
    add_word(OP_ASTORE_0,      16'h0);
    add_word(OP_ALOAD_0,       16'h0);
    add_word(OP_ILOAD_0 + 8'd2, 16'h0);
    add_word(OP_ILOAD_3,       16'h0);
    add_word(OP_LLOAD_0,       16'h0);
    add_word(OP_LLOAD_0 + 8'd1, 16'h0);
    add_word(OP_LLOAD_0 + 8'd2, 16'h0);
    add_word(OP_GOTO,          16'h8000);
    add_word(OP_GOTO,          16'h7FFF);
    add_word(OP_GOTO,          16'hFFFF);  // negative offset steps back one address
    add_word(OP_NOP,           16'h0);
    add_word(OP_IMPDEP2,       16'hFFFF);
    add_word(OP_INVOKESPECIAL, 16'h0);
    add_word(OP_NEW,           16'h0);
    add_word(OP_LRETURN,       16'h0);
    add_word(OP_ILOAD_0,       16'h0);     // fresh frame, locals reloaded
    add_word(OP_IRETURN,       16'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        load_args(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'h1);
      end else begin
        load_args(rand_slot(), rand_slot(), rand_slot(), rand_slot());
      end
      if (p < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 50;
      end else if (p < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) hold_arm = 1'b1;
      queued = 0;
      if (p == 5) begin
        while (queued < PHASE_WORDS / 2) gen_program();
        drain();
      end
      while (queued < PHASE_WORDS) gen_program();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  int unsigned cycle_cnt = 0;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule
